/* hw/rtl/pcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants of the parallelogram column span unit
// Field widths, search bounds, register indexes and the command and status
// structures exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int EDGE_W  = 21;
  localparam int TOTAL_W = 42;
  localparam int COL_W   = 21;
  localparam int SPAN_W  = 24;

  localparam int SEARCH_LIMIT = 8388607;

  // Search coordinates hold [-SEARCH_LIMIT, SEARCH_LIMIT].
  localparam int COORD_W = $clog2(SEARCH_LIMIT + 1) + 1;
  // An edge component after negation needs one extra bit.
  localparam int VEC_W   = EDGE_W + 1;
  localparam int MA_W    = (COORD_W > VEC_W) ? COORD_W : VEC_W;
  localparam int MB_W    = VEC_W;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int CMP_W   = PROD_W + 1;

  localparam int SEARCH_STEPS = $clog2(2 * SEARCH_LIMIT + 1);
  localparam int ISSUE_COUNT  = 2 * SEARCH_STEPS;
  localparam int CNT_W        = $clog2(ISSUE_COUNT);

  localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(SEARCH_LIMIT);
  localparam logic signed [COORD_W-1:0] Y_MIN = COORD_W'(-SEARCH_LIMIT);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TOTAL_W;

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_A_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_A_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_B_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_B_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CNT = 3'd4;

  localparam int S_TDATA_W   = ((COL_W + 7) / 8) * 8;
  localparam int M_DATA_BITS = 2 * SPAN_W + TOTAL_W + 1;
  localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;
  localparam int M_TUSER_W   = 2;

  typedef enum logic [1:0] {
    MUL_CROSS,
    MUL_COLUMN,
    MUL_SEARCH
  } mul_sel_e;

  typedef struct packed {
    logic signed [EDGE_W-1:0] ax;
    logic signed [EDGE_W-1:0] ay;
    logic signed [EDGE_W-1:0] bx;
    logic signed [EDGE_W-1:0] by;
    logic [TOTAL_W-1:0]       target;
  } cfg_t;

  typedef struct packed {
    logic     load_x;
    mul_sel_e mul_sel;
    logic     prep;
    logic     load_search;
    logic     issue;
    logic     sel;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic degenerate;
    logic out_of_range;
  } sts_t;

  typedef struct packed {
    logic signed [SPAN_W-1:0] span_low;
    logic signed [SPAN_W-1:0] span_high;
    logic [TOTAL_W-1:0]       total_points;
    logic                     total_matches;
    logic                     degenerate;
    logic                     out_of_range;
  } res_t;

endpackage

/* hw/rtl/pcs_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_cfg_regs: configuration register file
// Holds edge vectors A and B and the target count; writes to unused indexes
// are dropped.
// ----------------------------------------------------------------------------
module pcs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [pcs_pkg::CFG_IDX_W-1:0] wr_index_i,
  input  logic [pcs_pkg::CFG_DATA_W-1:0] wr_data_i,
  output pcs_pkg::cfg_t                 cfg_o
);
  import pcs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ax     <= EDGE_W'(1);
      cfg_q.ay     <= '0;
      cfg_q.bx     <= '0;
      cfg_q.by     <= EDGE_W'(1);
      cfg_q.target <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        REG_EDGE_A_X:   cfg_q.ax     <= wr_data_i[EDGE_W-1:0];
        REG_EDGE_A_Y:   cfg_q.ay     <= wr_data_i[EDGE_W-1:0];
        REG_EDGE_B_X:   cfg_q.bx     <= wr_data_i[EDGE_W-1:0];
        REG_EDGE_B_Y:   cfg_q.by     <= wr_data_i[EDGE_W-1:0];
        REG_TARGET_CNT: cfg_q.target <= wr_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/pcs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_ctrl: sequencing state machine
// Steps one column through setup, the two interleaved binary searches and
// result hand-off.
// ----------------------------------------------------------------------------
module pcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_free_i,
  input  pcs_pkg::sts_t sts_i,
  output pcs_pkg::cmd_t cmd_o
);
  import pcs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CROSS  = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_COLUMN = 3'd3;
  localparam logic [2:0] ST_LOAD   = 3'd4;
  localparam logic [2:0] ST_SEARCH = 3'd5;
  localparam logic [2:0] ST_DRAIN  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  cmd_t             cmd;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd         = '0;
    cmd.mul_sel = MUL_SEARCH;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load_x = 1'b1;
          state_d    = ST_CROSS;
        end
      end
      ST_CROSS: begin
        cmd.mul_sel = MUL_CROSS;
        state_d     = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_d  = ST_COLUMN;
      end
      ST_COLUMN: begin
        cmd.mul_sel = MUL_COLUMN;
        if (sts_i.degenerate || sts_i.out_of_range) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_search = 1'b1;
        cnt_d           = '0;
        state_d         = ST_SEARCH;
      end
      ST_SEARCH: begin
        // Even slots serve the lower-bound search, odd slots the upper one.
        cmd.issue = 1'b1;
        cmd.sel   = cnt_q[0];
        if (cnt_q == CNT_W'(ISSUE_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          cmd.finish = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cmd_o = cmd;

endmodule

/* hw/rtl/pcs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_datapath: edge normalization, edge tests and span accumulation
// Two registered multipliers serve the cross product, the per-column terms
// and every search probe; the four tests against the edges reduce to
// compares of a probe product against per-column thresholds.
// ----------------------------------------------------------------------------
module pcs_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pcs_pkg::cmd_t             cmd_i,
  input  pcs_pkg::cfg_t             cfg_i,
  input  logic [pcs_pkg::COL_W-1:0] column_i,
  output pcs_pkg::sts_t             sts_o,
  output pcs_pkg::res_t             res_o
);
  import pcs_pkg::*;

  logic signed [EDGE_W-1:0] ax_s, ay_s, bx_s, by_s;
  logic [COL_W-1:0]         x_q;

  logic signed [MA_W-1:0]   m_a0, m_a1;
  logic signed [MB_W-1:0]   m_b0, m_b1;
  logic signed [PROD_W-1:0] prod0_q, prod1_q;

  logic signed [VEC_W-1:0]  nax, nay, nbx, nby;
  logic signed [CMP_W-1:0]  cross_w;
  logic                     flip;
  logic [VEC_W:0]           far_x;
  logic signed [VEC_W-1:0]  px_q, py_q, qx_q, qy_q;
  logic signed [CMP_W-1:0]  d_q;
  logic                     degen_q, oor_q;

  logic signed [CMP_W-1:0]  xpy_q, xqy_q, xpyd_q, xqyd_q;
  logic signed [COORD_W-1:0] lo1_q, hi1_q, lo2_q, hi2_q;

  logic signed [COORD_W-1:0] i_lo, i_hi, mid;
  logic signed [COORD_W:0]   i_diff, i_half;
  logic signed [COORD_W-1:0] mid_q;
  logic                      eval_valid_q, eval_sel_q;

  logic signed [COORD_W-1:0] e_lo, e_hi;
  logic signed [CMP_W-1:0]   p0, p1;
  logic                      active, t1, t2, t3, t4, below, above;

  logic signed [COORD_W+1:0] len;
  logic [TOTAL_W-1:0]        len_ext, base, new_total, total_q;
  res_t                      res;

  assign ax_s = cfg_i.ax;
  assign ay_s = cfg_i.ay;
  assign bx_s = cfg_i.bx;
  assign by_s = cfg_i.by;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= column_i;
    end
  end

  // Probe coordinate of the search issued this cycle.
  always_comb begin
    i_lo   = cmd_i.sel ? lo2_q : lo1_q;
    i_hi   = cmd_i.sel ? hi2_q : hi1_q;
    i_diff = (COORD_W+1)'(i_hi) - (COORD_W+1)'(i_lo);
    if (cmd_i.sel) begin
      i_half = (i_diff + (COORD_W+1)'(1)) >>> 1;
    end else begin
      i_half = i_diff >>> 1;
    end
    mid = COORD_W'((COORD_W+1)'(i_lo) + i_half);
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_CROSS: begin
        m_a0 = MA_W'(ax_s);
        m_b0 = MB_W'(by_s);
        m_a1 = MA_W'(ay_s);
        m_b1 = MB_W'(bx_s);
      end
      MUL_COLUMN: begin
        m_a0 = MA_W'({1'b0, x_q});
        m_b0 = py_q;
        m_a1 = MA_W'({1'b0, x_q});
        m_b1 = qy_q;
      end
      default: begin
        m_a0 = MA_W'(mid);
        m_b0 = px_q;
        m_a1 = MA_W'(mid);
        m_b1 = qx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod0_q <= PROD_W'(m_a0) * PROD_W'(m_b0);
    prod1_q <= PROD_W'(m_a1) * PROD_W'(m_b1);
    mid_q   <= mid;
  end

  // Normalize both vectors to non-negative x, then order them so that
  // the cross product is positive.
  always_comb begin
    nax     = ax_s[EDGE_W-1] ? -VEC_W'(ax_s) : VEC_W'(ax_s);
    nay     = ax_s[EDGE_W-1] ? -VEC_W'(ay_s) : VEC_W'(ay_s);
    nbx     = bx_s[EDGE_W-1] ? -VEC_W'(bx_s) : VEC_W'(bx_s);
    nby     = bx_s[EDGE_W-1] ? -VEC_W'(by_s) : VEC_W'(by_s);
    cross_w = CMP_W'(prod0_q) - CMP_W'(prod1_q);
    flip    = cross_w[CMP_W-1] ^ ax_s[EDGE_W-1] ^ bx_s[EDGE_W-1];
    far_x   = {1'b0, nax} + {1'b0, nbx};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      px_q    <= flip ? nbx : nax;
      py_q    <= flip ? nby : nay;
      qx_q    <= flip ? nax : nbx;
      qy_q    <= flip ? nay : nby;
      d_q     <= cross_w[CMP_W-1] ? -cross_w : cross_w;
      degen_q <= (cross_w == '0);
      oor_q   <= ((VEC_W+1)'(x_q) > far_x);
    end
  end

  assign sts_o.degenerate   = degen_q;
  assign sts_o.out_of_range = oor_q;

  // Evaluation of the probe issued in the cycle before.
  always_comb begin
    e_lo   = eval_sel_q ? lo2_q : lo1_q;
    e_hi   = eval_sel_q ? hi2_q : hi1_q;
    active = eval_valid_q && (e_lo < e_hi);
    p0     = CMP_W'(prod0_q);
    p1     = CMP_W'(prod1_q);
    t1     = p0 < xpy_q;
    t2     = p1 >= xqy_q;
    t3     = p1 < xqyd_q;
    t4     = p0 >= xpyd_q;
    below  = t1 || (!t2 && t3);
    above  = !t1 && (t2 || (!t3 && t4));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_valid_q <= 1'b0;
      eval_sel_q   <= 1'b0;
    end else begin
      eval_valid_q <= cmd_i.issue;
      eval_sel_q   <= cmd_i.sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_search) begin
      xpy_q  <= CMP_W'(prod0_q);
      xqy_q  <= CMP_W'(prod1_q);
      xpyd_q <= CMP_W'(prod0_q) + d_q;
      xqyd_q <= CMP_W'(prod1_q) - d_q;
      lo1_q  <= Y_MIN;
      hi1_q  <= Y_MAX;
      lo2_q  <= Y_MIN;
      hi2_q  <= Y_MAX;
    end else if (active) begin
      if (!eval_sel_q) begin
        if (below) begin
          lo1_q <= mid_q + COORD_W'(1);
        end else begin
          hi1_q <= mid_q;
        end
      end else begin
        if (above) begin
          hi2_q <= mid_q - COORD_W'(1);
        end else begin
          lo2_q <= mid_q;
        end
      end
    end
  end

  // Span length may be zero or negative; it is added as a signed value.
  always_comb begin
    len       = (COORD_W+2)'(lo2_q) - (COORD_W+2)'(lo1_q) + (COORD_W+2)'(1);
    len_ext   = TOTAL_W'(len);
    base      = (x_q == '0) ? '0 : total_q;
    new_total = base + len_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.finish && !degen_q && !oor_q) begin
      total_q <= new_total;
    end
  end

  always_comb begin
    res = '0;
    if (degen_q) begin
      res.degenerate = 1'b1;
    end else if (oor_q) begin
      res.total_points  = total_q;
      res.total_matches = (total_q == cfg_i.target);
      res.out_of_range  = 1'b1;
    end else begin
      res.span_low      = SPAN_W'(lo1_q);
      res.span_high     = SPAN_W'(lo2_q);
      res.total_points  = new_total;
      res.total_matches = (new_total == cfg_i.target);
    end
  end

  assign res_o = res;

endmodule

/* hw/rtl/parallelogram_column_span_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallelogram_column_span_unit: column span rasterizer for a parallelogram
// For each requested column, finds the lowest and highest y inside the
// half-open parallelogram spanned by edge vectors A and B and keeps a running
// lattice point total.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Width  Contents
//   s_axis    in         24     column
//   m_axis    out        96+2   span, running total, match flag; tuser flags
//   cfg       in         3+42   register index and write data
//
// One column passes from acceptance to the result register through the setup
// states (cross, prep, column, load), the two binary searches and the drain
// and hand-off states. The searches make 24 probes each in alternating slots;
// every probe uses both registered multipliers, one per cycle. The next
// column is accepted in the cycle after the hand-off; no new column is taken
// before it. Degenerate vectors and columns beyond the far corner skip the
// searches and go from the column state straight to the hand-off.
// Reset clears the state machine, the running total, the configuration
// registers (to the unit square) and the output valid flag.
// A result held in the output register does not block a new column; only
// the final hand-off waits while the output is still occupied.
//
module parallelogram_column_span_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: column [20:0], zero fill above.
  input  logic [pcs_pkg::S_TDATA_W-1:0]  s_axis_tdata,

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: span_low [23:0], span_high [47:24], total_points [89:48],
  // total_matches [90], zero fill above.
  output logic [pcs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: degenerate [0], out_of_range [1].
  output logic [pcs_pkg::M_TUSER_W-1:0]  m_axis_tuser,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pcs_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  res_t res;

  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [M_TUSER_W-1:0] out_user_q;
  logic                 out_free;

  // Always taken; the user must land writes while the unit is idle, unchecked.
  assign cfg_ready_o = 1'b1;

  pcs_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcs_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .cfg_i    (cfg),
    .column_i (s_axis_tdata[COL_W-1:0]),
    .sts_o    (sts),
    .res_o    (res)
  );

  // Output register: loaded on the controller's hand-off, cleared once the
  // downstream side completes the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) begin
      out_data_q <= {{(M_TDATA_W - M_DATA_BITS){1'b0}}, res.total_matches,
                     res.total_points, res.span_high, res.span_low};
      out_user_q <= {res.out_of_range, res.degenerate};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
